// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL; scvf_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCVF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SCVF_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define SCVF_ASSERT(lbl, clk, rst_n, prop)
`define SCVF_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: hw/rtl/scvf_pkg.sv
`default_nettype none
package scvf_pkg;

  typedef enum logic [1:0] {
    MODE_DASH,
    MODE_BLANK,
    MODE_RENDER
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] value;
  } item_t;

  localparam logic [2:0] DT_U8  = 3'd0;
  localparam logic [2:0] DT_U16 = 3'd1;
  localparam logic [2:0] DT_U32 = 3'd2;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_PLACES = 2'd1;
  localparam logic [1:0] REG_MAXDIG = 2'd2;

  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_DASH  = 7'h2D;
  localparam logic [6:0] CH_HASH  = 7'h23;
  localparam logic [6:0] CH_ZERO  = 7'h30;

endpackage
`default_nettype wire

// File: hw/rtl/scvf_front.sv
`default_nettype none
module scvf_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_raw_value,
  input  wire logic [2:0]         in_data_type,
  input  wire logic               in_value_valid,
  input  wire logic               in_flash_enable,
  input  wire logic [31:0]        in_time_ms,
  output logic                    q_push,
  output scvf_pkg::item_t         q_item,
  input  wire logic               q_full
);

  typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} fstate_t;

  fstate_t         state_r;
  scvf_pkg::item_t item_r;
  logic [27:0]     fold_r;
  logic [3:0]      low_r;
  logic [27:0]     fold_nxt;
  logic [6:0]      r125;
  logic [10:0]     rem;
  logic [31:0]     value_sel;

  // t mod 2000 = 16 * ((t >> 4) mod 125) + t[3:0]; since 128 = 3 mod 125,
  // fold the upper bits down (at most 6 folds) until the value fits in 7 bits
  always_comb begin
    fold_nxt = {7'd0, fold_r[27:7]} + {6'd0, fold_r[27:7], 1'b0} +
               {21'd0, fold_r[6:0]};
    r125     = (fold_r[6:0] >= 7'd125) ? fold_r[6:0] - 7'd125 : fold_r[6:0];
    rem      = {r125, low_r};
  end

  always_comb begin
    case (in_data_type)
      scvf_pkg::DT_U8:  value_sel = {24'd0, in_raw_value[7:0]};
      scvf_pkg::DT_U16: value_sel = {16'd0, in_raw_value[15:0]};
      scvf_pkg::DT_U32: value_sel = in_raw_value;
      default:          value_sel = 32'hFFFF_FFFF;
    endcase
  end

  assign in_stall = (state_r != F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            item_r.value <= value_sel;
            fold_r       <= in_time_ms[31:4];
            low_r        <= in_time_ms[3:0];
            if (!in_value_valid) begin
              item_r.mode <= scvf_pkg::MODE_DASH;
              state_r     <= F_PUSH;
            end else if (in_flash_enable) begin
              state_r <= F_MOD;
            end else begin
              item_r.mode <= scvf_pkg::MODE_RENDER;
              state_r     <= F_PUSH;
            end
          end
        end
        F_MOD: begin
          if (fold_r[27:7] != 21'd0) begin
            fold_r <= fold_nxt;
          end else begin
            item_r.mode <= (rem < 11'd1000) ? scvf_pkg::MODE_BLANK
                                            : scvf_pkg::MODE_RENDER;
            state_r     <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scvf_queue.sv
`default_nettype none
module scvf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  scvf_pkg::item_t      push_item,
  output logic                 full,
  input  wire logic            pop,
  output scvf_pkg::item_t      head_item,
  output logic                 not_empty
);

  scvf_pkg::item_t entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_item = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scvf_back.sv
`default_nettype none
`include "assert_macros.svh"
module scvf_back #(
  parameter int TEXT_LENGTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic signed [4:0]  decimal_scale,
  input  wire logic [3:0]         decimal_places,
  input  wire logic [3:0]         max_digits,
  input  wire logic               q_not_empty,
  input  scvf_pkg::item_t         q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [6:0]              out_char_code,
  output logic                    out_last_char,
  output logic                    out_text_changed
);

  localparam int IDXW = $clog2(TEXT_LENGTH);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TEXT_LENGTH - 1);
  localparam logic signed [7:0] LAST_POS = 8'(TEXT_LENGTH - 1);

  typedef enum logic [2:0] {B_IDLE, B_CONV, B_PREP, B_BUILD, B_EMIT} bstate_t;

  bstate_t              state_r;
  scvf_pkg::mode_t      mode_r;
  logic [31:0]          val_r;
  logic [9:0][3:0]      bcd_r;
  logic [4:0]           cnt_r;
  logic [IDXW-1:0]      idx_r;
  logic signed [7:0]    ip_r;
  logic [3:0]           n_r;
  logic                 hash_r;
  logic                 changed_r;
  logic [6:0]           buf_r [TEXT_LENGTH];
  logic                 out_valid_r;
  logic [6:0]           out_char_r;
  logic                 out_last_r;
  logic                 out_changed_r;

  logic [9:0][3:0]      bcd_adj;
  logic [3:0]           n_calc;
  logic signed [7:0]    ip_calc;
  logic signed [7:0]    disp_calc;
  logic signed [7:0]    pos, dp, md, total, point_at, tpos, int_len, p;
  logic [6:0]           old_ch, new_ch, err_ch;
  logic                 load_out, emit_last;

  function automatic logic [6:0] digit_ch(logic [9:0][3:0] b, logic [3:0] n,
                                          logic signed [7:0] pp);
    logic [3:0] k;
    k = 4'(n - 4'(pp) - 4'd1);
    if (pp >= 0 && pp < $signed({4'd0, n}) && k < 4'd10) begin
      return scvf_pkg::CH_ZERO | {3'd0, b[k]};
    end
    return scvf_pkg::CH_ZERO;
  endfunction

  // double dabble step
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_comb begin
    n_calc = 4'd1;
    for (int i = 0; i < 10; i++) begin
      if (bcd_r[i] != 4'd0) n_calc = 4'(i + 1);
    end
    ip_calc   = $signed({4'd0, n_calc}) + 8'(decimal_scale);
    disp_calc = (ip_calc < 0) ? dp + 8'sd1 : ip_calc + dp;
  end

  // character for buffer position idx_r under the current mode
  always_comb begin
    pos      = $signed({{(8-IDXW){1'b0}}, idx_r});
    dp       = $signed({4'd0, decimal_places});
    md       = $signed({4'd0, max_digits});
    total    = md + ((decimal_places != 4'd0) ? 8'sd1 : 8'sd0);
    point_at = md - dp;
    tpos     = (total > LAST_POS) ? LAST_POS : total;
    int_len  = (ip_r <= 0) ? 8'sd1 : ip_r;
    p        = ip_r + pos - int_len - 8'sd1;
    old_ch   = buf_r[idx_r];
    err_ch   = (mode_r == scvf_pkg::MODE_DASH) ? scvf_pkg::CH_DASH : scvf_pkg::CH_HASH;
    new_ch   = scvf_pkg::CH_NUL;
    if (mode_r == scvf_pkg::MODE_BLANK) begin
      new_ch = (idx_r == '0) ? scvf_pkg::CH_NUL : old_ch;
    end else if (mode_r == scvf_pkg::MODE_DASH || hash_r) begin
      if (pos < total && pos < LAST_POS) begin
        new_ch = (pos == point_at) ? scvf_pkg::CH_DOT : err_ch;
      end else if (pos == tpos) begin
        new_ch = scvf_pkg::CH_NUL;
      end else begin
        new_ch = (mode_r == scvf_pkg::MODE_DASH) ? old_ch : scvf_pkg::CH_NUL;
      end
    end else if (pos >= LAST_POS) begin
      new_ch = scvf_pkg::CH_NUL;
    end else if (pos < int_len) begin
      new_ch = (ip_r <= 0) ? scvf_pkg::CH_ZERO : digit_ch(bcd_r, n_r, pos);
    end else if (dp > 0 && pos == int_len) begin
      new_ch = scvf_pkg::CH_DOT;
    end else if (dp > 0 && pos <= int_len + dp) begin
      new_ch = digit_ch(bcd_r, n_r, p);
    end
  end

  assign q_pop     = (state_r == B_IDLE) && q_not_empty;
  assign load_out  = (state_r == B_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = (old_ch == scvf_pkg::CH_NUL) || (idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      changed_r   <= 1'b0;
      for (int i = 0; i < TEXT_LENGTH; i++) buf_r[i] <= scvf_pkg::CH_NUL;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_not_empty) begin
            mode_r    <= q_item.mode;
            val_r     <= q_item.value;
            bcd_r     <= '0;
            cnt_r     <= '0;
            hash_r    <= 1'b0;
            idx_r     <= '0;
            changed_r <= 1'b0;
            state_r   <= (q_item.mode == scvf_pkg::MODE_RENDER) ? B_CONV : B_BUILD;
          end
        end
        B_CONV: begin
          bcd_r   <= 40'({bcd_adj, val_r[31]});
          val_r   <= {val_r[30:0], 1'b0};
          cnt_r   <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= B_PREP;
        end
        B_PREP: begin
          n_r     <= n_calc;
          ip_r    <= ip_calc;
          hash_r  <= (disp_calc > md);
          state_r <= B_BUILD;
        end
        B_BUILD: begin
          buf_r[idx_r] <= new_ch;
          if (new_ch != old_ch) changed_r <= 1'b1;
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            state_r <= B_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        B_EMIT: begin
          if (load_out) begin
            out_char_r    <= emit_last ? scvf_pkg::CH_NUL : old_ch;
            out_last_r    <= emit_last;
            out_changed_r <= emit_last && changed_r;
            if (emit_last) begin
              state_r <= B_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_code    = out_char_r;
  assign out_last_char    = out_last_r;
  assign out_text_changed = out_changed_r;

  `SCVF_ASSERT(a_last_is_nul, clk, rst_n, (out_valid_r && out_last_r) |-> (out_char_r == scvf_pkg::CH_NUL))
  `SCVF_NEVER(a_changed_only_last, clk, rst_n, out_valid_r && out_changed_r && !out_last_r)
  `SCVF_NEVER(a_tail_nul, clk, rst_n, buf_r[LAST_IDX] != scvf_pkg::CH_NUL)

endmodule
`default_nettype wire

// File: hw/rtl/scaled_decimal_value_formatter.sv
`default_nettype none
// Scaled decimal value formatter.
// Input channel (in_*): one transaction per sampled value with its type code,
// valid flag, flash flag and millisecond time. in_stall is high while the
// front end holds a transaction: while time mod 2000 of a flashing value is
// found by folding, and until its item is pushed into the queue.
// Output channel (out_*): one transaction per character of the rendered
// text, ending with a NUL transaction that has out_last_char set and reports
// in out_text_changed whether the kept text differs from the previous one.
// Config channel (cfg_*): cfg_ready is always high; index 0 decimal_scale,
// 1 decimal_places, 2 max_digits. Write only while the block is idle.
// Back end per value: a pop from the queue, binary to BCD conversion and a
// prep step (rendered values only), a rewrite of the text buffer position by
// position, then one character per cycle while out_stall is low. A two-entry
// queue between front and back lets new values be classified while one is
// still emitted.
// Reset (synchronous, rst_n low) empties the queue, clears the text buffer
// to NULs and loads the config defaults (scale 0, places 0, max digits 5).
// A stalled output holds its character; the back end waits.
module scaled_decimal_value_formatter #(
  parameter int TEXT_LENGTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  in_raw_value,
  input  wire logic [2:0]   in_data_type,
  input  wire logic         in_value_valid,
  input  wire logic         in_flash_enable,
  input  wire logic [31:0]  in_time_ms,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [6:0]        out_char_code,
  output logic              out_last_char,
  output logic              out_text_changed,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [4:0]   cfg_data
);

  logic signed [4:0] scale_r;
  logic [3:0]        places_r;
  logic [3:0]        maxdig_r;

  logic              q_push, q_full, q_pop, q_not_empty;
  scvf_pkg::item_t   q_in, q_head;

  assign cfg_ready = 1'b1;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 5'sd0;
      places_r <= 4'd0;
      maxdig_r <= 4'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        scvf_pkg::REG_SCALE:  scale_r  <= $signed(cfg_data);
        scvf_pkg::REG_PLACES: places_r <= cfg_data[3:0];
        scvf_pkg::REG_MAXDIG: maxdig_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  scvf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_raw_value    (in_raw_value),
    .in_data_type    (in_data_type),
    .in_value_valid  (in_value_valid),
    .in_flash_enable (in_flash_enable),
    .in_time_ms      (in_time_ms),
    .q_push          (q_push),
    .q_item          (q_in),
    .q_full          (q_full)
  );

  scvf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head),
    .not_empty (q_not_empty)
  );

  scvf_back #(
    .TEXT_LENGTH (TEXT_LENGTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .decimal_scale    (scale_r),
    .decimal_places   (places_r),
    .max_digits       (maxdig_r),
    .q_not_empty      (q_not_empty),
    .q_item           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_code    (out_char_code),
    .out_last_char    (out_last_char),
    .out_text_changed (out_text_changed)
  );

endmodule
`default_nettype wire
